// ===== design/els_pkg.sv =====
// Shared types and constants for the edge list search block.
`default_nettype none

package els_pkg;

    localparam int POS_FIELD_W = 7;
    localparam int START_W     = 6;
    localparam int THR_W       = 8;
    localparam int COUNT_W     = 7;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 1;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_READ_L = 3'd2,
        CMD_READ_R = 3'd3,
        CMD_FIND_L = 3'd4,
        CMD_FIND_R = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        POL_ANY  = 2'd0,
        POL_RISE = 2'd1,
        POL_FALL = 2'd2
    } pol_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_WALK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                   found;
        logic [POS_FIELD_W-1:0] edge_pos;
        logic                   edge_rising;
        logic [COUNT_W-1:0]     edge_count;
    } res_t;

endpackage

`default_nettype wire

// ===== design/els_mem.sv =====
// Edge store: single-port-write, registered-read synchronous memory.
`default_nettype none

module els_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/els_out.sv =====
// Output register stage for result requests.
`default_nettype none

module els_out
    import els_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    output logic                      res_ready,
    input  wire res_t                 res,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // edge_pos[6:0], edge_rising, edge_count[6:0], 0
    output logic      [M_TUSER_W-1:0] m_tuser   // found
);

    logic valid_reg;
    logic valid_next;
    res_t data_reg;
    res_t data_next;

    always_comb
    begin
        res_ready  = !valid_reg || m_tready;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg.edge_count, data_reg.edge_rising, data_reg.edge_pos};
    assign m_tuser  = data_reg.found;

endmodule

`default_nettype wire

// ===== design/els_ctrl.sv =====
// Command sequencer: clear, append, indexed read and walking search over the edge store.
`default_nettype none

module els_ctrl
    import els_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int POS_BITS = 7,
    parameter int ADDR_W   = 6,
    parameter int CNT_W    = 7
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             cmd,
    input  wire logic [POS_FIELD_W-1:0] position,
    input  wire logic                   rising,
    input  wire logic [START_W-1:0]     start_index,
    input  wire logic [THR_W-1:0]       threshold,
    input  wire logic [1:0]             polarity,
    output logic                        wr_en,
    output logic      [ADDR_W-1:0]      wr_addr,
    output logic      [POS_BITS:0]      wr_data,
    output logic                        rd_en,
    output logic      [ADDR_W-1:0]      rd_addr,
    input  wire logic [POS_BITS:0]      rd_data,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output res_t                        res
);

    localparam int IDX_W = (CNT_W > START_W) ? CNT_W : START_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    state_t               state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic                 ris_reg, ris_next;
    logic [START_W-1:0]   start_reg, start_next;
    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [1:0]           pol_reg, pol_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    res_t                 res_reg, res_next;

    logic                 is_right;
    logic [IDX_W-1:0]     count_ext;
    logic [IDX_W-1:0]     walk_idx;
    logic [IDX_W-1:0]     slot;
    logic                 app_fall;
    logic [POS_BITS-1:0]  rd_pos;
    logic                 rd_fall;
    logic                 beyond;
    logic                 pol_ok;

    always_comb
    begin
        is_right  = (cmd_reg == CMD_READ_R) || (cmd_reg == CMD_FIND_R);
        count_ext = IDX_W'(count_reg);
        walk_idx  = (state_reg == ST_WALK) ? idx_reg : IDX_W'(start_reg);
        slot      = is_right ? (count_ext - IDX_W'(1) - walk_idx) : walk_idx;
        app_fall  = !ris_reg && (pos_reg != '0);
        rd_pos    = rd_data[POS_BITS-1:0];
        rd_fall   = rd_data[POS_BITS];
        beyond    = is_right ? (THR_W'(rd_pos) < thr_reg) : (THR_W'(rd_pos) > thr_reg);
        unique case (pol_reg)
            POL_ANY:  pol_ok = 1'b1;
            POL_RISE: pol_ok = !rd_fall;
            POL_FALL: pol_ok = rd_fall;
            default:  pol_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        ris_next   = ris_reg;
        start_next = start_reg;
        thr_next   = thr_reg;
        pol_next   = pol_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        in_ready   = (state_reg == ST_IDLE);
        res_valid  = (state_reg == ST_RESULT);
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        wr_data    = {app_fall, pos_reg};
        rd_en      = 1'b0;
        rd_addr    = slot[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    pos_next   = position[POS_BITS-1:0];
                    ris_next   = rising;
                    start_next = start_index;
                    thr_next   = threshold;
                    pol_next   = polarity;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_next            = '0;
                res_next.edge_count = COUNT_W'(count_reg);
                state_next          = ST_RESULT;
                unique case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        count_next          = '0;
                        res_next.edge_count = '0;
                    end
                    CMD_APPEND:
                    begin
                        if (count_reg != FULL_COUNT)
                        begin
                            wr_en                = 1'b1;
                            count_next           = count_reg + CNT_W'(1);
                            res_next.found       = 1'b1;
                            res_next.edge_pos    = POS_FIELD_W'(pos_reg);
                            res_next.edge_rising = !app_fall;
                            res_next.edge_count  = COUNT_W'(count_next);
                        end
                    end
                    CMD_READ_L, CMD_READ_R:
                    begin
                        if (IDX_W'(start_reg) < count_ext)
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                    end
                    CMD_FIND_L, CMD_FIND_R:
                    begin
                        idx_next   = IDX_W'(start_reg);
                        pend_next  = 1'b0;
                        state_next = ST_WALK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                res_next.found       = 1'b1;
                res_next.edge_pos    = POS_FIELD_W'(rd_pos);
                res_next.edge_rising = !rd_fall;
                state_next           = ST_RESULT;
            end
            ST_WALK:
            begin
                priority if (pend_reg && beyond && pol_ok)
                begin
                    res_next.found       = 1'b1;
                    res_next.edge_pos    = POS_FIELD_W'(rd_pos);
                    res_next.edge_rising = !rd_fall;
                    state_next           = ST_RESULT;
                end
                else if (idx_reg < count_ext)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + IDX_W'(1);
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        ris_reg   <= ris_next;
        start_reg <= start_next;
        thr_reg   <= thr_next;
        pol_reg   <= pol_next;
        idx_reg   <= idx_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== design/edge_list_search.sv =====
// Top level of the scan-line edge store with indexed read and threshold search.
//
// One request channel (s_*) and one result channel (m_*), both valid/ready.
// A request carries a command in s_tuser: clear, append, read from the left
// or right, find from the left or right. Every request yields exactly one
// result; m_tuser is found, m_tdata carries the edge and the stored count.
// Requests are handled one at a time. Clear, append, an unused command and an
// out-of-range read pass the execute and result states, then the output
// register, on the way to m_tvalid; an in-range read adds a read-wait state.
// A find walks the entries from the start index up to a hit, or to the end of
// the list on a miss (none is read when start is at or beyond the count);
//   the walk reads one memory entry per cycle through the single read port.
// A new request is taken while the previous result still sits in the output
// register; if the receiver stalls, the finished result is held in the
// sequencer and s_tready stays low until the output register frees up.
// Reset empties the store (count = 0) at once; no clearing pass is needed
// since entries at or beyond the count are never read.
`default_nettype none

module edge_list_search
    import els_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int POS_BITS = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // position[6:0], rising, start_index[5:0],
                                                // threshold[7:0], polarity[1:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // cmd[2:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // edge_pos[6:0], edge_rising, edge_count[6:0], 0
    output logic      [M_TUSER_W-1:0] m_tuser   // found
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [POS_BITS:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [POS_BITS:0]   rd_data;
    logic                res_valid;
    logic                res_ready;
    res_t                res;

    els_ctrl #(
        .DEPTH    (DEPTH),
        .POS_BITS (POS_BITS),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .cmd         (s_tuser[2:0]),
        .position    (s_tdata[6:0]),
        .rising      (s_tdata[7]),
        .start_index (s_tdata[13:8]),
        .threshold   (s_tdata[21:14]),
        .polarity    (s_tdata[23:22]),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    els_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (POS_BITS + 1),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    els_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/els_checker.sv =====
// Port-level assertions for the edge list search block, bound to the top level.
`default_nettype none

module els_checker #(
    parameter int DEPTH = 64
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("miss result carries edge data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (DEPTH > 127) || (m_tdata[14:8] <= 7'(DEPTH)))
        else $error("edge count above store depth");

endmodule

bind edge_list_search els_checker #(.DEPTH(DEPTH)) u_els_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
